@@ hw/rtl/qts_pkg.sv @@
// ----------------------------------------------------------------------------
// Quoted token splitter package
// Shared types and character codes for the quoted token splitter.
// ----------------------------------------------------------------------------
package qts_pkg;

   // One input item: a text byte or an end-of-input mark.
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_input;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] token_byte;
      logic       truncated;
   } rsp_type;

   // Result kinds.
   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_END       = 2'd1;
   localparam logic [1:0] KIND_NONE_LEFT = 2'd2;

   // Character codes the scanner reacts to.
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUOTE   = 8'h22;

   // Whitespace test used between tokens and at the end of bare tokens.
   function automatic logic is_blank(input logic [7:0] ch);
      is_blank = (ch == CH_TAB) || (ch == CH_NEWLINE) || (ch == CH_CR) || (ch == CH_SPACE);
   endfunction

endpackage

@@ hw/rtl/quoted_token_splitter_core.sv @@
// ----------------------------------------------------------------------------
// Quoted token splitter core
// Splits a byte stream into bare and quoted tokens, skipping whitespace and
// hash comments.
// ----------------------------------------------------------------------------
// The block takes one byte or end-of-input mark per cycle and gives at most
// one result per item: a token byte, a token end (with a truncated flag when
// bytes past MAX_LEN-1 were dropped), or a no-more-tokens mark. An accepted
// item is held in an input register, classified there against the scan mode,
// and its result is written to an output register, from which it is presented
// to the downstream side until it transfers. The sustained rate is one item
// per cycle; it drops only while a waiting result is held back by rsp_stall
// and the next item also has a result to deliver.
module quoted_token_splitter_core
   import qts_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    accept;
   logic    advance;
   logic    scan_has_rsp;
   rsp_type scan_rsp;
   logic    out_room;

   // An item moves on unless its result finds the output register full and held by rsp_stall.
   assign advance   = in_valid_ff && (!scan_has_rsp || out_room);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   // Scan logic and mode state.
   qts_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .item    (in_data_ff),
      .step    (advance),
      .has_rsp (scan_has_rsp),
      .rsp     (scan_rsp)
   );

   // Result register toward the downstream side.
   qts_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && scan_has_rsp),
      .load_data (scan_rsp),
      .room      (out_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An input stall happens only behind a held result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result register could take a transfer");

   // A result that leaves the scanner is presented in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (advance && scan_has_rsp) |=> (rsp_valid && rsp_data == $past(scan_rsp)))
      else $error("scanner result lost on its way to the output");

   // Only defined kinds leave the block, and truncation only with a token end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.result_kind == KIND_BYTE ||
                      rsp_data.result_kind == KIND_END ||
                      rsp_data.result_kind == KIND_NONE_LEFT) &&
                     (!rsp_data.truncated || rsp_data.result_kind == KIND_END)))
      else $error("malformed result");

endmodule

@@ hw/rtl/qts_scan.sv @@
// ----------------------------------------------------------------------------
// Quoted token splitter scanner
// Holds the scan mode, token length and overflow flag, and decides the result
// of one item in a single pass of logic.
// ----------------------------------------------------------------------------
module qts_scan
   import qts_pkg::*;
#(
   parameter int MAX_LEN = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type item,
   input  logic    step,
   output logic    has_rsp,
   output rsp_type rsp
);

   localparam int LEN_W = $clog2(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 1);

   typedef enum logic [1:0] {
      MODE_BETWEEN = 2'd0,
      MODE_COMMENT = 2'd1,
      MODE_QUOTED  = 2'd2,
      MODE_BARE    = 2'd3
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       ch;
   logic             eoi;

   assign ch  = item.byte_value;
   assign eoi = item.end_of_input;

   // Next state and result for the item at the input register.
   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      has_rsp = 1'b0;
      rsp     = '0;
      case (mode_ff)
         MODE_BETWEEN, MODE_COMMENT: begin
            if (eoi) begin
               mode_in         = MODE_BETWEEN;
               len_in          = '0;
               ovf_in          = 1'b0;
               has_rsp         = 1'b1;
               rsp.result_kind = KIND_NONE_LEFT;
            end else if (mode_ff == MODE_COMMENT) begin
               if (ch == CH_NEWLINE) begin
                  mode_in = MODE_BETWEEN;
               end
            end else if (ch == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (!is_blank(ch)) begin
               ovf_in = 1'b0;
               if (ch == CH_QUOTE) begin
                  mode_in = MODE_QUOTED;
                  len_in  = '0;
               end else begin
                  // The first byte of a bare token always fits.
                  mode_in         = MODE_BARE;
                  len_in          = LEN_W'(1);
                  has_rsp         = 1'b1;
                  rsp.result_kind = KIND_BYTE;
                  rsp.token_byte  = ch;
               end
            end
         end
         default: begin
            // Inside a quoted or bare token.
            if (eoi || (mode_ff == MODE_QUOTED && ch == CH_QUOTE) ||
                (mode_ff == MODE_BARE && is_blank(ch))) begin
               mode_in         = MODE_BETWEEN;
               len_in          = '0;
               ovf_in          = 1'b0;
               has_rsp         = 1'b1;
               rsp.result_kind = KIND_END;
               rsp.truncated   = ovf_ff;
            end else if (len_ff < LEN_LIMIT) begin
               len_in          = len_ff + LEN_W'(1);
               has_rsp         = 1'b1;
               rsp.result_kind = KIND_BYTE;
               rsp.token_byte  = ch;
            end else begin
               ovf_in = 1'b1;
            end
         end
      endcase
   end

   // Scan state advances when the item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BETWEEN;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

@@ hw/rtl/qts_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// Quoted token splitter result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module qts_rsp_reg
   import qts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    room,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // The register can take a new result when empty or being emptied now.
   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ verif/quoted_token_splitter_core_tb.sv @@
// ----------------------------------------------------------------------------
// Quoted token splitter core testbench
// Feeds the splitter a directed script and then random text built from bare
// tokens, quoted tokens, comments, whitespace and end-of-input marks. Every
// result transfer is checked field by field against a scanner kept in the
// testbench or, for some directed rows, against a fixed expected result.
// Sender idling and receiver stalls vary from phase to phase.
module quoted_token_splitter_core_tb
   import qts_pkg::*;
();

   localparam int TOKEN_MAX_LEN = 256;
   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 265;
   localparam int NUM_PHASES    = 5;

   // How a directed row gets its expected result.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_RSP
   } row_check_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          eoi;
      row_check_type how;
      rsp_type       rsp;
   } script_row_type;

   // Scanner modes of the testbench copy of the splitter.
   typedef enum logic [1:0] {
      SCAN_BETWEEN,
      SCAN_COMMENT,
      SCAN_QUOTED,
      SCAN_BARE
   } scan_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   scan_mode_type scan_state   = SCAN_BETWEEN;
   int            kept_count   = 0;
   logic          dropped_flag = 1'b0;

   rsp_type token_queue[$];
   rsp_type want;

   int items_sent       = 0;
   int results_seen     = 0;
   int bytes_seen       = 0;
   int token_ends_seen  = 0;
   int truncations_seen = 0;
   int none_left_seen   = 0;
   int fail_count       = 0;
   int quiet_cycles     = 0;
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int hold_count       = 0;

   int SEND_IDLE [NUM_PHASES]  = '{0, 49, 0, 36, 0};
   int RECV_STALL [NUM_PHASES] = '{0, 0, 49, 36, 0};

   logic [7:0] BLANKS [4] = '{CH_TAB, CH_NEWLINE, CH_CR, CH_SPACE};

   // Directed script: both stream boundaries, every blank, both quote roles,
   // empty quoted token, end of input between tokens, in a comment and in a quoted token, and the byte extremes.
   script_row_type directed_script [25] = '{
      '{8'h00, 1'b1, ROW_RSP, '{KIND_NONE_LEFT, 8'h00, 1'b0}},
      '{8'hff, 1'b1, ROW_RSP, '{KIND_NONE_LEFT, 8'h00, 1'b0}},
      '{CH_TAB, 1'b0, ROW_NONE, '0},
      '{CH_NEWLINE, 1'b0, ROW_NONE, '0},
      '{CH_SPACE, 1'b0, ROW_NONE, '0},
      '{8'h61, 1'b0, ROW_PREDICT, '0},
      '{CH_QUOTE, 1'b0, ROW_PREDICT, '0},
      '{CH_HASH, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_PREDICT, '0},
      '{8'hff, 1'b0, ROW_PREDICT, '0},
      '{CH_SPACE, 1'b0, ROW_RSP, '{KIND_END, 8'h00, 1'b0}},
      '{CH_QUOTE, 1'b0, ROW_NONE, '0},
      '{CH_QUOTE, 1'b0, ROW_RSP, '{KIND_END, 8'h00, 1'b0}},
      '{CH_QUOTE, 1'b0, ROW_NONE, '0},
      '{CH_SPACE, 1'b0, ROW_PREDICT, '0},
      '{CH_TAB, 1'b0, ROW_PREDICT, '0},
      '{CH_HASH, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b1, ROW_RSP, '{KIND_END, 8'h00, 1'b0}},
      '{CH_HASH, 1'b0, ROW_NONE, '0},
      '{8'h78, 1'b0, ROW_NONE, '0},
      '{8'h00, 1'b1, ROW_RSP, '{KIND_NONE_LEFT, 8'h00, 1'b0}},
      '{CH_HASH, 1'b0, ROW_NONE, '0},
      '{CH_NEWLINE, 1'b0, ROW_NONE, '0},
      '{8'hff, 1'b0, ROW_PREDICT, '0},
      '{CH_CR, 1'b0, ROW_RSP, '{KIND_END, 8'h00, 1'b0}}
   };

   quoted_token_splitter_core #(
      .MAX_LEN(TOKEN_MAX_LEN)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Whitespace as the scanner sees it.
   function automatic logic is_space_char(input logic [7:0] ch);
      return ch == CH_TAB || ch == CH_NEWLINE || ch == CH_CR || ch == CH_SPACE;
   endfunction

   // Keeps a token byte while there is room, otherwise marks the token cut.
   function automatic logic keep_char(input logic [7:0] ch, output rsp_type res);
      res = '0;
      if (kept_count < TOKEN_MAX_LEN - 1) begin
         kept_count++;
         res.result_kind = KIND_BYTE;
         res.token_byte  = ch;
         return 1'b1;
      end
      dropped_flag = 1'b1;
      return 1'b0;
   endfunction

   // Closes the current token and reports whether bytes were dropped.
   function automatic logic close_token(output rsp_type res);
      res             = '0;
      res.result_kind = KIND_END;
      res.truncated   = dropped_flag;
      scan_state      = SCAN_BETWEEN;
      kept_count      = 0;
      dropped_flag    = 1'b0;
      return 1'b1;
   endfunction

   // Advances the scanner by one input transfer; returns 1 when a result is due.
   function automatic logic scan_byte(input req_type item, output rsp_type res);
      logic [7:0] ch;
      logic       eoi;
      ch  = item.byte_value;
      eoi = item.end_of_input;
      res = '0;
      case (scan_state)
         SCAN_BETWEEN, SCAN_COMMENT: begin
            if (eoi) begin
               scan_state      = SCAN_BETWEEN;
               kept_count      = 0;
               dropped_flag    = 1'b0;
               res.result_kind = KIND_NONE_LEFT;
               return 1'b1;
            end
            if (scan_state == SCAN_COMMENT) begin
               if (ch == CH_NEWLINE) scan_state = SCAN_BETWEEN;
               return 1'b0;
            end
            if (ch == CH_HASH) begin
               scan_state = SCAN_COMMENT;
               return 1'b0;
            end
            if (is_space_char(ch)) return 1'b0;
            kept_count   = 0;
            dropped_flag = 1'b0;
            if (ch == CH_QUOTE) begin
               scan_state = SCAN_QUOTED;
               return 1'b0;
            end
            scan_state = SCAN_BARE;
            return keep_char(ch, res);
         end
         SCAN_QUOTED: begin
            if (eoi || ch == CH_QUOTE) return close_token(res);
            return keep_char(ch, res);
         end
         default: begin
            if (eoi || is_space_char(ch)) return close_token(res);
            return keep_char(ch, res);
         end
      endcase
   endfunction

   // Offers one item, waits for its transfer and records the expected result.
   // Each cycle before the offer is idle with the phase's sender idle chance.
   task automatic send_item(input logic [7:0] ch, input logic eoi,
                            input row_check_type how = ROW_PREDICT,
                            input rsp_type fixed = '0);
      req_type item;
      rsp_type res;
      logic    yields;
      item.byte_value   = ch;
      item.end_of_input = eoi;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      yields = scan_byte(item, res);
      if (how == ROW_NONE) begin
         yields = 1'b0;
      end else if (how == ROW_RSP) begin
         yields = 1'b1;
         res    = fixed;
      end
      if (yields) token_queue.push_back(res);
      items_sent++;
   endtask

   // Random token character; a bare token never starts with a hash or quote.
   function automatic logic [7:0] pick_char(input logic quoted, input logic first);
      logic [7:0] ch;
      do begin
         ch = 8'($urandom_range(255));
      end while (quoted ? (ch == CH_QUOTE) :
                 (is_space_char(ch) || (first && (ch == CH_HASH || ch == CH_QUOTE))));
      return ch;
   endfunction

   // Sends a whole token with its delimiter; sometimes end of input closes it.
   task automatic send_token(input logic quoted, input int len);
      if (quoted) send_item(CH_QUOTE, 1'b0);
      for (int i = 0; i < len; i++) send_item(pick_char(quoted, i == 0), 1'b0);
      if ($urandom_range(7) == 0) send_item(8'($urandom_range(255)), 1'b1);
      else if (quoted) send_item(CH_QUOTE, 1'b0);
      else send_item(BLANKS[2'($urandom_range(3))], 1'b0);
   endtask

   // One random piece of text: mostly well-formed, with some raw noise.
   task automatic send_segment();
      int         pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_token(1'b0, $urandom_range(1, 10));
      end else if (pick < 55) begin
         send_token(1'b1, $urandom_range(0, 10));
      end else if (pick < 72) begin
         repeat ($urandom_range(1, 3)) send_item(BLANKS[2'($urandom_range(3))], 1'b0);
      end else if (pick < 82) begin
         send_item(CH_HASH, 1'b0);
         repeat ($urandom_range(0, 6)) begin
            ch = 8'($urandom_range(255));
            if (ch == CH_NEWLINE) ch = CH_SPACE;
            send_item(ch, 1'b0);
         end
         send_item(CH_NEWLINE, 1'b0);
      end else if (pick < 90) begin
         send_item(8'($urandom_range(255)), 1'b1);
      end else begin
         repeat ($urandom_range(1, 3))
            send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
   endtask

   // Drops valid and waits for every outstanding result.
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
   endtask

   // Receiver: a counted hold-off when requested, otherwise random stalls.
   always @(negedge clock) begin
      if (hold_count > 0) begin
         rsp_stall  <= 1'b1;
         hold_count = hold_count - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Result checker: each result transfer against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         case (rsp_data.result_kind)
            KIND_BYTE: bytes_seen++;
            KIND_END: begin
               token_ends_seen++;
               if (rsp_data.truncated) truncations_seen++;
            end
            KIND_NONE_LEFT: none_left_seen++;
            default: ;
         endcase
         if (token_queue.size() == 0) begin
            $error("unexpected result: kind %0d byte 0x%02h truncated %0d",
                   rsp_data.result_kind, rsp_data.token_byte, rsp_data.truncated);
            fail_count++;
         end else begin
            want = token_queue.pop_front();
            if (rsp_data.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d",
                      want.result_kind, rsp_data.result_kind);
               fail_count++;
            end
            if (rsp_data.token_byte !== want.token_byte) begin
               $error("token_byte: expected 0x%02h, got 0x%02h",
                      want.token_byte, rsp_data.token_byte);
               fail_count++;
            end
            if (rsp_data.truncated !== want.truncated) begin
               $error("truncated: expected %0d, got %0d", want.truncated, rsp_data.truncated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("** quoted_token_splitter_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int phase_end;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script, no idling on either side.
      foreach (directed_script[i]) begin
         send_item(directed_script[i].ch, directed_script[i].eoi,
                   directed_script[i].how, directed_script[i].rsp);
      end
      pause_until_drained();

      // Random phases; all but the last open with a long token at or past the size
      // limit, and the last one starts with a long receiver hold-off.
      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         if (p == NUM_PHASES - 1) hold_count = 80;
         phase_end = items_sent + PHASE_ITEMS;
         case (p)
            0: send_token(1'b0, 300);
            1: send_token(1'b0, TOKEN_MAX_LEN - 1);
            2: send_token(1'b1, TOKEN_MAX_LEN);
            3: send_token(1'b1, 280);
            default: ;
         endcase
         while (items_sent < phase_end) send_segment();
         pause_until_drained();
      end

      repeat (8) @(posedge clock);
      if (token_queue.size() != 0) begin
         $error("%0d expected results never arrived", token_queue.size());
         fail_count++;
      end

      $display("Run covered %0d input transfers and %0d result transfers.",
               items_sent, results_seen);
      $display("Seen: %0d token bytes, %0d token ends (%0d cut short), %0d stream ends.",
               bytes_seen, token_ends_seen, truncations_seen, none_left_seen);
      if (fail_count == 0) begin
         $display("** quoted_token_splitter_core: PASSED **");
      end else begin
         $display("** quoted_token_splitter_core: FAILED **");
      end
      $finish;
   end

endmodule
